@@ rtl/core/iabst_pkg.sv @@
// ----------------------------------------------------------------------------
// iabst_pkg: shared types and constants of the array-based search tree engine
// Holds the beat structs, the command and status codes and the state machine
// type that the controller and the datapath share.
// ----------------------------------------------------------------------------
package iabst_pkg;

   localparam int NodeCount = 63;
   localparam int KeyWidth  = 32;
   localparam int IdxW      = 6;
   localparam int DepthMax  = 6;
   localparam int SpW       = 3;

   typedef enum logic [1:0] {
      CMD_INSERT   = 2'd0,
      CMD_INORDER  = 2'd1,
      CMD_PREORDER = 2'd2,
      CMD_POSTORD  = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_INSERTED  = 3'd0,
      ST_DUPLICATE = 3'd1,
      ST_NO_ROOM   = 3'd2,
      ST_DUMPED    = 3'd3,
      ST_EMPTY     = 3'd4
   } status_type;

   typedef struct packed {
      logic [1:0]         cmd;
      logic signed [31:0] key;
   } req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic signed [31:0] key_out;
      logic               last;
      logic [5:0]         leaf_count;
      logic [4:0]         inner_count;
      logic [2:0]         tree_height;
   } rsp_type;

   typedef enum logic [3:0] {
      FSM_IDLE,
      FSM_INS_RD,
      FSM_INS_CMP,
      FSM_DMP_VISIT,
      FSM_DMP_RD,
      FSM_DMP_EMIT,
      FSM_DMP_NEXT,
      FSM_OUT
   } fsm_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_req;    // capture the request beat, reset walk state
      logic ins_step;    // evaluate one level of the insert descent
      logic dmp_visit;   // examine the node at the top of the walk stack
      logic dmp_next;    // advance the walk after an emission
      logic emit;        // load the output register
   } dp_cmd_type;

   // Status back to the controller.
   typedef struct packed {
      logic ins_done;    // insert result ready to emit
      logic visit_emit;  // visit found a key to emit now
      logic visit_done;  // walk finished, nothing more to emit
      logic is_insert;
      logic is_empty;
   } dp_sts_type;

endpackage

@@ rtl/core/iabst_ram.sv @@
// ----------------------------------------------------------------------------
// iabst_ram: generic simple dual-port RAM with registered read
// One write port and one read port at independent addresses.
// ----------------------------------------------------------------------------
module iabst_ram #(
   parameter int Width = 32,
   parameter int Depth = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

@@ rtl/core/iabst_datapath.sv @@
// ----------------------------------------------------------------------------
// iabst_datapath: node store, used marks, walk stack and counters
// Executes the insert descent and the stack-driven traversals under command
// of the controller, and holds the output beat register.
// ----------------------------------------------------------------------------
module iabst_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  iabst_pkg::req_type   req_data,
   input  iabst_pkg::dp_cmd_type cmd_in,
   output iabst_pkg::dp_sts_type sts_out,
   output iabst_pkg::rsp_type   rsp_data
);
   import iabst_pkg::*;

   logic [NodeCount-1:0] used_ff, used_in;
   logic [1:0]           cmd_ff;
   logic [31:0]          key_ff;
   logic [IdxW-1:0]      idx_ff, idx_in;
   logic [5:0]           leaf_ff, leaf_in;
   logic [4:0]           inner_ff, inner_in;
   logic [2:0]           height_ff, height_in;
   logic [2:0]           lvl_ff, lvl_in;
   logic [2:0]           ins_st_ff, ins_st_in;
   rsp_type              rsp_ff, rsp_in;

   // Walk stack: node index and a phase per level (0 new, 1 left done, 2 right done).
   logic [IdxW-1:0]      stk_idx_ff [DepthMax];
   logic [1:0]           stk_ph_ff  [DepthMax];
   logic [IdxW-1:0]      stk_idx_in [DepthMax];
   logic [1:0]           stk_ph_in  [DepthMax];
   logic [SpW-1:0]       sp_ff, sp_in;
   logic                 stk_empty_ff, stk_empty_in;

   logic                 wr_en;
   logic [IdxW-1:0]      rd_addr;
   logic [31:0]          rd_data;
   logic [31:0]          key_sx;
   logic [IdxW:0]        left_w, right_w;
   logic                 cur_used, less;
   logic [IdxW-1:0]      top_idx, sib_idx;
   logic [1:0]           top_ph;
   logic [IdxW:0]        child_w;
   logic                 child_ok;
   logic [IdxW:0]        top_right_w;
   logic                 top_has_right;
   logic [IdxW:0]        anc_right_w;
   logic                 anc_done;

   // Sign extension from KeyWidth bits.
   assign key_sx = {{(32-KeyWidth){req_data.key[KeyWidth-1]}},
                    req_data.key[KeyWidth-1:0]};

   assign top_idx = stk_idx_ff[sp_ff];
   assign top_ph  = stk_ph_ff[sp_ff];
   assign rd_addr = (cmd_ff == CMD_INSERT) ? idx_ff : top_idx;

   iabst_ram #(.Width(32), .Depth(64)) u_keys (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (idx_ff),
      .wr_data (key_ff),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff      <= '0;
         leaf_ff      <= '0;
         inner_ff     <= '0;
         height_ff    <= '0;
         sp_ff        <= '0;
         stk_empty_ff <= 1'b1;
      end else begin
         used_ff      <= used_in;
         leaf_ff      <= leaf_in;
         inner_ff     <= inner_in;
         height_ff    <= height_in;
         sp_ff        <= sp_in;
         stk_empty_ff <= stk_empty_in;
      end
      cmd_ff    <= cmd_in.load_req ? req_data.cmd : cmd_ff;
      key_ff    <= cmd_in.load_req ? key_sx : key_ff;
      idx_ff    <= idx_in;
      lvl_ff    <= lvl_in;
      ins_st_ff <= ins_st_in;
      rsp_ff    <= rsp_in;
      stk_idx_ff <= stk_idx_in;
      stk_ph_ff  <= stk_ph_in;
   end

   // The key at the top of the stack is the final one of the traversal only if
   // no ancestor below it still owes a key of its own or of its right subtree.
   always_comb begin
      top_right_w   = {top_idx, 1'b0} + 7'd2;
      top_has_right = (top_right_w < 7'(NodeCount)) && used_ff[top_right_w[IdxW-1:0]];
      anc_done      = 1'b1;
      anc_right_w   = '0;
      for (int j = 0; j < DepthMax; j++) begin
         anc_right_w = {stk_idx_ff[j], 1'b0} + 7'd2;
         if (3'(j) < sp_ff) begin
            if (cmd_ff == CMD_POSTORD) begin
               anc_done = 1'b0;
            end else if (stk_ph_ff[j] != 2'd2) begin
               if (cmd_ff == CMD_INORDER || ((anc_right_w < 7'(NodeCount)) &&
                   used_ff[anc_right_w[IdxW-1:0]])) begin
                  anc_done = 1'b0;
               end
            end
         end
      end
   end

   always_comb begin
      used_in      = used_ff;
      leaf_in      = leaf_ff;
      inner_in     = inner_ff;
      height_in    = height_ff;
      idx_in       = idx_ff;
      lvl_in       = lvl_ff;
      ins_st_in    = ins_st_ff;
      rsp_in       = rsp_ff;
      stk_idx_in   = stk_idx_ff;
      stk_ph_in    = stk_ph_ff;
      sp_in        = sp_ff;
      stk_empty_in = stk_empty_ff;
      wr_en        = 1'b0;
      sts_out      = '0;
      cur_used     = used_ff[idx_ff];
      less         = $signed(key_ff) < $signed(rd_data);
      left_w       = {idx_ff, 1'b1};
      right_w      = {idx_ff, 1'b0} + 7'd2;
      sib_idx      = idx_ff[0] ? idx_ff + 6'd1 : idx_ff - 6'd1;
      child_w      = (top_ph == 2'd0) ? {top_idx, 1'b1} : {top_idx, 1'b0} + 7'd2;
      child_ok     = (child_w < 7'(NodeCount)) && used_ff[child_w[IdxW-1:0]];

      sts_out.is_insert = (req_data.cmd == CMD_INSERT);
      sts_out.is_empty  = !used_ff[0];

      if (cmd_in.load_req) begin
         idx_in       = '0;
         lvl_in       = '0;
         sp_in        = '0;
         stk_idx_in[0] = '0;
         stk_ph_in[0]  = 2'd0;
         stk_empty_in = 1'b0;
      end

      if (cmd_in.ins_step) begin
         if (!cur_used) begin
            wr_en         = 1'b1;
            used_in[idx_ff] = 1'b1;
            ins_st_in     = ST_INSERTED;
            sts_out.ins_done = 1'b1;
            if (idx_ff == '0) begin
               leaf_in = 6'd1;
            end else if (sib_idx < 6'(NodeCount) && used_ff[sib_idx]) begin
               leaf_in = leaf_ff + 6'd1;
            end else begin
               inner_in = inner_ff + 5'd1;
            end
            if (lvl_ff + 3'd1 > height_ff) begin
               height_in = lvl_ff + 3'd1;
            end
         end else if (rd_data == key_ff) begin
            ins_st_in = ST_DUPLICATE;
            sts_out.ins_done = 1'b1;
         end else begin
            if (less) begin
               idx_in = left_w[IdxW-1:0];
               if (left_w >= 7'(NodeCount)) begin
                  ins_st_in = ST_NO_ROOM;
                  sts_out.ins_done = 1'b1;
               end
            end else begin
               idx_in = right_w[IdxW-1:0];
               if (right_w >= 7'(NodeCount)) begin
                  ins_st_in = ST_NO_ROOM;
                  sts_out.ins_done = 1'b1;
               end
            end
            lvl_in = lvl_ff + 3'd1;
         end
      end

      // One visit step: decide whether the top node emits now, descends or pops, or report the end of the walk.
      if (cmd_in.dmp_visit) begin
         if (stk_empty_ff) begin
            sts_out.visit_done = 1'b1;
         end else if ((cmd_ff == CMD_PREORDER && top_ph == 2'd0) ||
                      (cmd_ff == CMD_INORDER && top_ph == 2'd1) ||
                      (cmd_ff == CMD_POSTORD && top_ph == 2'd2)) begin
            sts_out.visit_emit = 1'b1;
         end else begin
            if (top_ph == 2'd2) begin
               if (sp_ff == '0) begin
                  stk_empty_in = 1'b1;
               end else begin
                  sp_in = sp_ff - 3'd1;
               end
            end else begin
               stk_ph_in[sp_ff] = top_ph + 2'd1;
               if (child_ok) begin
                  sp_in = sp_ff + 3'd1;
                  stk_idx_in[sp_ff + 3'd1] = child_w[IdxW-1:0];
                  stk_ph_in[sp_ff + 3'd1]  = 2'd0;
               end
            end
         end
      end

      // After an emission the top node's phase moves on as if visited.
      if (cmd_in.dmp_next) begin
         if (top_ph == 2'd2) begin
            if (sp_ff == '0) begin
               stk_empty_in = 1'b1;
            end else begin
               sp_in = sp_ff - 3'd1;
            end
         end else begin
            stk_ph_in[sp_ff] = top_ph + 2'd1;
            if (child_ok) begin
               sp_in = sp_ff + 3'd1;
               stk_idx_in[sp_ff + 3'd1] = child_w[IdxW-1:0];
               stk_ph_in[sp_ff + 3'd1]  = 2'd0;
            end
         end
      end

      if (cmd_in.emit) begin
         rsp_in.leaf_count  = leaf_ff;
         rsp_in.inner_count = inner_ff;
         rsp_in.tree_height = height_ff;
         if (cmd_ff == CMD_INSERT) begin
            rsp_in.status  = ins_st_ff;
            rsp_in.key_out = key_ff;
            rsp_in.last    = 1'b1;
         end else if (!used_ff[0]) begin
            rsp_in.status  = ST_EMPTY;
            rsp_in.key_out = '0;
            rsp_in.last    = 1'b1;
         end else begin
            rsp_in.status  = ST_DUMPED;
            rsp_in.key_out = rd_data;
            rsp_in.last    = anc_done && (cmd_ff == CMD_POSTORD ||
                             (cmd_ff == CMD_INORDER && !top_has_right) ||
                             (cmd_ff == CMD_PREORDER && !child_ok && !top_has_right));
         end
      end
   end

   assign rsp_data = rsp_ff;
endmodule

@@ rtl/core/iabst_ctrl.sv @@
// ----------------------------------------------------------------------------
// iabst_ctrl: sequencing state machine of the search tree engine
// Orders the insert descent, the traversal steps and the output handshake.
// ----------------------------------------------------------------------------
module iabst_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  logic                  rsp_last,
   input  iabst_pkg::dp_sts_type sts_in,
   output iabst_pkg::dp_cmd_type cmd_out
);
   import iabst_pkg::*;

   fsm_type state_ff, state_in;
   logic    dump_ff, dump_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FSM_IDLE;
         dump_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         dump_ff  <= dump_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      dump_in   = dump_ff;
      cmd_out   = '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         FSM_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd_out.load_req = 1'b1;
               if (sts_in.is_insert) begin
                  dump_in  = 1'b0;
                  state_in = FSM_INS_RD;
               end else if (sts_in.is_empty) begin
                  dump_in  = 1'b0;
                  state_in = FSM_DMP_EMIT;
               end else begin
                  dump_in  = 1'b1;
                  state_in = FSM_DMP_VISIT;
               end
            end
         end
         FSM_INS_RD: state_in = FSM_INS_CMP;
         FSM_INS_CMP: begin
            cmd_out.ins_step = 1'b1;
            state_in = sts_in.ins_done ? FSM_DMP_EMIT : FSM_INS_RD;
         end
         FSM_DMP_VISIT: begin
            cmd_out.dmp_visit = 1'b1;
            if (sts_in.visit_done) begin
               state_in = FSM_IDLE;
            end else if (sts_in.visit_emit) begin
               state_in = FSM_DMP_RD;
            end
         end
         FSM_DMP_RD: state_in = FSM_DMP_EMIT;
         FSM_DMP_EMIT: begin
            cmd_out.emit = 1'b1;
            state_in = FSM_OUT;
         end
         FSM_OUT: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               if (dump_ff && !rsp_last) begin
                  state_in = FSM_DMP_NEXT;
               end else begin
                  state_in = FSM_IDLE;
               end
            end
         end
         FSM_DMP_NEXT: begin
            cmd_out.dmp_next = 1'b1;
            state_in = FSM_DMP_VISIT;
         end
         default: state_in = FSM_IDLE;
      endcase
   end
endmodule

@@ rtl/core/implicit_array_bst_engine.sv @@
// ----------------------------------------------------------------------------
// implicit_array_bst_engine: binary search tree held in an implicit node array
// Top level joining the sequencing controller and the tree datapath.
// ----------------------------------------------------------------------------
// The tree keeps up to 63 signed keys in a node store where the children of
// node i sit at 2i+1 and 2i+2. An insert beat walks down from the root one
// level at a time; every step waits for the registered read of the key store
// before it compares, and the insert then returns a single result beat. A
// dump beat streams every stored key in the requested order; each key passes
// through the visit step, the key store read, the output load, the beat
// itself and the stack step after it, with a further stack step for each
// node that is left or passed through without emitting. A dump of an empty
// tree returns one beat with the empty status. Every result beat carries the
// current leaf count, inner-node count and height. One request is worked at
// a time; the request side stalls until the last result beat of the previous
// request has been taken. The used marks are cleared by reset directly, so
// no clearing pass is needed.
module implicit_array_bst_engine (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  iabst_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output iabst_pkg::rsp_type rsp_data
);
   import iabst_pkg::*;

   dp_cmd_type dp_cmd;
   dp_sts_type dp_sts;

   iabst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_last  (rsp_data.last),
      .sts_in    (dp_sts),
      .cmd_out   (dp_cmd)
   );

   iabst_datapath u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd_in   (dp_cmd),
      .sts_out  (dp_sts),
      .rsp_data (rsp_data)
   );
endmodule
